// File: rtl/alpi_pkg.sv
// alpi_pkg: shared widths, codes and control types of the arc-length path interpolator
// no dependencies; imported by alpi_lane, alpi_sqrt, alpi_div and the top level

package alpi_pkg;

  // default sizes
  localparam int MAX_POINTS_DEF = 256;
  localparam int MAX_DIM_DEF    = 8;

  // field widths
  localparam int FIELD_LANES = 8;
  localparam int COORD_W     = 32;
  localparam int FRAC_W      = 17;
  localparam int CMD_W       = 2;
  localparam int STAT_W      = 2;
  localparam int SEG_W       = 8;
  localparam int CFG_W       = 4;

  // stream packing
  localparam int IN_DATA_W  = 280;
  localparam int OUT_DATA_W = 264;
  localparam int FRAC_LSB   = FIELD_LANES * COORD_W;
  localparam int SEG_LSB    = FIELD_LANES * COORD_W;

  // arithmetic widths
  localparam int DIFF_W    = COORD_W + 1;
  localparam int SQ_W      = 65;
  localparam int SUM_W     = 68;
  localparam int SQRT_W    = 35;
  localparam int SQ_RAD_W  = 2 * SQRT_W;
  localparam int SQ_REM_W  = SQRT_W + 3;
  localparam int LEN_W     = 48;
  localparam int PROD_W    = DIFF_W + FRAC_W + 1;

  localparam logic [FRAC_W-1:0] ONE_Q16 = 17'h10000;

  // commands
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  // per-lane control from the sequencer
  typedef struct packed {
    logic cap_a;
    logic cap_b;
    logic do_sq;
    logic do_mul;
  } lane_ctrl_t;

endpackage

// File: rtl/alpi_ram.sv
// alpi_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies

module alpi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/alpi_lane.sv
// alpi_lane: one coordinate lane: point storage, squared difference, interpolation product
// depends on alpi_pkg and alpi_ram

module alpi_lane import alpi_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [$clog2(MAX_POINTS)-1:0] wr_addr,
  input  logic [COORD_W-1:0]            wr_data,
  input  logic [$clog2(MAX_POINTS)-1:0] rd_addr,
  input  lane_ctrl_t                    ctrl,
  input  logic [FRAC_W-1:0]             factor,
  output logic [SQ_W-1:0]               sq,
  output logic [COORD_W-1:0]            pos
);

  logic [COORD_W-1:0]       rd_data;
  logic [COORD_W-1:0]       pa;
  logic [COORD_W-1:0]       pb;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        mag;
  logic [2*DIFF_W-1:0]      sq_full;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_rnd;

  alpi_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // difference and magnitude of the two captured points
  assign diff    = DIFF_W'($signed(pb)) - DIFF_W'($signed(pa));
  assign mag     = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign sq_full = mag * mag;

  // capture points, square and scale
  always_ff @(posedge clk) begin
    if (ctrl.cap_a) begin
      pa <= rd_data;
    end
    if (ctrl.cap_b) begin
      pb <= rd_data;
    end
    if (ctrl.do_sq) begin
      sq <= sq_full[SQ_W-1:0];
    end
    if (ctrl.do_mul) begin
      prod <= PROD_W'(diff) * $signed({1'b0, factor});
    end
  end

  // round half up, floor shift, add start point
  assign prod_rnd = prod + PROD_W'(32768);
  assign pos      = pa + prod_rnd[COORD_W+15:16];

endmodule

// File: rtl/alpi_sqrt.sv
// alpi_sqrt: iterative integer square root, two radicand bits per cycle
// depends on alpi_pkg

module alpi_sqrt import alpi_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SUM_W-1:0]  radicand,
  output logic [SQRT_W-1:0] root,
  output logic              done
);

  logic                    busy;
  logic [5:0]              cnt;
  logic [SQ_RAD_W-1:0]     rad;
  logic [SQ_REM_W-1:0]     rem;
  logic [SQ_REM_W-1:0]     rem_sh;
  logic [SQ_REM_W-1:0]     trial;

  assign rem_sh = {rem[SQ_REM_W-3:0], rad[SQ_RAD_W-1 -: 2]};
  assign trial  = SQ_REM_W'({root, 2'b01});

  // one result bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rad  <= SQ_RAD_W'(radicand);
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rad <= {rad[SQ_RAD_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[SQRT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[SQRT_W-2:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'(SQRT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/alpi_div.sv
// alpi_div: restoring divider for the segment factor, one quotient bit per cycle
// depends on alpi_pkg; the numerator never exceeds the denominator

module alpi_div import alpi_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SQRT_W-1:0] num,
  input  logic [SQRT_W-1:0] den,
  output logic [FRAC_W-1:0] quo,
  output logic              done
);

  logic              busy;
  logic [4:0]        cnt;
  logic [SQRT_W-1:0] dreg;
  logic [SQRT_W:0]   rem;
  logic [SQRT_W:0]   rem_sh;

  // the first step takes the integer bit without a shift
  assign rem_sh = (cnt == '0) ? rem : {rem[SQRT_W-1:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= {1'b0, num};
        dreg <= den;
        quo  <= '0;
      end else if (busy) begin
        if (rem_sh >= {1'b0, dreg}) begin
          rem <= rem_sh - {1'b0, dreg};
          quo <= {quo[FRAC_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[FRAC_W-2:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'(FRAC_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/arc_length_path_interpolator_unit.sv
// arc_length_path_interpolator_unit: top level, sequencer, lane merge and output register
// depends on alpi_pkg, alpi_lane, alpi_sqrt, alpi_div, alpi_ram
//
// channel  dir  signals                      contents (low bit up)
// config   in   cfg_we, cfg_wdata[3:0]       dim
// request  in   s_tvalid/s_tready/s_tdata    tdata: coord_0..coord_7, frac; tuser: cmd
// result   out  m_tvalid/m_tready/m_tdata    tdata: pos_0..pos_7, segment; tuser: status
//
// clear, append and no-op requests go from the idle state straight to the output state.
// a query runs each of its segment lengths through the 35-step square root;
// the walk then reads the stored lengths back, and the factor divide comes last.
// rst is synchronous; it empties the path and sets dim to 1.
// a finished result waits in the output register while the next request is taken.

module arc_length_path_interpolator_unit import alpi_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int MAX_DIM    = MAX_DIM_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_W-1:0]      cfg_wdata,   // dim
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,     // coord_0..coord_7, frac, zero pad
  input  logic [CMD_W-1:0]      s_tuser,     // cmd
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,     // pos_0..pos_7, segment
  output logic [STAT_W-1:0]     m_tuser      // status
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int LW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001,
    S_RDA  = 16'h0002,
    S_RDB  = 16'h0004,
    S_CPB  = 16'h0008,
    S_SQ   = 16'h0010,
    S_ACC  = 16'h0020,
    S_SQRT = 16'h0040,
    S_WANT = 16'h0080,
    S_WALK = 16'h0100,
    S_WADD = 16'h0200,
    S_DIV  = 16'h0400,
    S_PRA  = 16'h0800,
    S_PRB  = 16'h1000,
    S_PCB  = 16'h2000,
    S_PMUL = 16'h4000,
    S_OUT  = 16'h8000
  } state_t;

  state_t              state;
  logic [CFG_W-1:0]    dim;
  logic [CFG_W-1:0]    d_eff;
  logic [CW-1:0]       count;
  logic [LEN_W-1:0]    total;
  logic [CW-1:0]       seg;
  logic [CFG_W-1:0]    k;
  logic [SUM_W-1:0]    acc;
  logic [SUM_W-1:0]    acc_sum;
  logic [FRAC_W-1:0]   frac;
  logic [FRAC_W-1:0]   frac_in;
  logic [LEN_W-1:0]    wanted;
  logic [LEN_W+FRAC_W-1:0] tf;
  logic [LEN_W-1:0]    act;
  logic [LEN_W-1:0]    rest;
  logic [SQRT_W-1:0]   last;
  logic [CW-1:0]       idx;
  logic                walk_go;
  logic [AW-1:0]       p0;
  logic [AW-1:0]       p1;
  logic [FRAC_W-1:0]   fct;
  logic [STAT_W-1:0]   res_status;
  logic                res_pos;
  logic                out_free;
  logic                accept;
  logic                app_we;

  lane_ctrl_t          lane_ctrl;
  logic [AW-1:0]       rd_addr;
  logic [SQ_W-1:0]     sq_lane [MAX_DIM];
  logic [COORD_W-1:0]  pos_sel [FIELD_LANES];

  logic                sq_start;
  logic [SQRT_W-1:0]   sq_root;
  logic                sq_done;
  logic                dv_start;
  logic [FRAC_W-1:0]   dv_quo;
  logic                dv_done;

  logic                sl_we;
  logic [AW-1:0]       sl_rd_addr;
  logic [SQRT_W-1:0]   sl_rdata;

  // effective lane count
  always_comb begin
    if (dim == '0) begin
      d_eff = CFG_W'(1);
    end else if (dim > CFG_W'(MAX_DIM)) begin
      d_eff = CFG_W'(MAX_DIM);
    end else begin
      d_eff = dim;
    end
  end

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign app_we   = accept && (s_tuser == CMD_APPEND) && (count < CW'(MAX_POINTS));
  assign frac_in  = s_tdata[FRAC_LSB +: FRAC_W];
  assign acc_sum  = acc + SUM_W'(sq_lane[k[LW-1:0]]);
  assign tf       = total * frac;
  assign walk_go  = (act < wanted) && (({1'b0, idx} + 1'b1) < {1'b0, count});
  assign rest     = wanted - (act - LEN_W'(last));

  // lanes
  for (genvar g = 0; g < FIELD_LANES; g++) begin : g_lane
    if (g < MAX_DIM) begin : g_used
      logic [COORD_W-1:0] lane_pos;
      alpi_lane #(.MAX_POINTS(MAX_POINTS)) u_lane (
        .clk    (clk),
        .wr_en  (app_we),
        .wr_addr(count[AW-1:0]),
        .wr_data(s_tdata[g*COORD_W +: COORD_W]),
        .rd_addr(rd_addr),
        .ctrl   (lane_ctrl),
        .factor (fct),
        .sq     (sq_lane[g]),
        .pos    (lane_pos)
      );
      assign pos_sel[g] = (res_pos && (CFG_W'(g) < d_eff)) ? lane_pos : '0;
    end else begin : g_unused
      assign pos_sel[g] = '0;
    end
  end

  alpi_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sq_start),
    .radicand(acc_sum),
    .root    (sq_root),
    .done    (sq_done)
  );

  alpi_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(dv_start),
    .num  (rest[SQRT_W-1:0]),
    .den  (last),
    .quo  (dv_quo),
    .done (dv_done)
  );

  // segment lengths of the latest query
  assign sl_we      = (state == S_SQRT) && sq_done;
  assign sl_rd_addr = AW'(idx + 1'b1);

  alpi_ram #(.WIDTH(SQRT_W), .DEPTH(MAX_POINTS)) u_seglen (
    .clk    (clk),
    .wr_en  (sl_we),
    .wr_addr(seg[AW-1:0]),
    .wr_data(sq_root),
    .rd_addr(sl_rd_addr),
    .rd_data(sl_rdata)
  );

  // lane read address and lane strobes
  always_comb begin
    lane_ctrl = '0;
    rd_addr   = '0;
    sq_start  = 1'b0;
    dv_start  = 1'b0;
    unique case (state)
      S_RDA:  rd_addr = AW'(seg - 1'b1);
      S_RDB: begin
        rd_addr         = seg[AW-1:0];
        lane_ctrl.cap_a = 1'b1;
      end
      S_CPB:  lane_ctrl.cap_b = 1'b1;
      S_SQ:   lane_ctrl.do_sq = 1'b1;
      S_ACC:  sq_start = (k == d_eff - 1'b1);
      S_WALK: dv_start = !walk_go && (idx != '0) && (last != '0);
      S_PRA:  rd_addr = p0;
      S_PRB: begin
        rd_addr         = p1;
        lane_ctrl.cap_a = 1'b1;
      end
      S_PCB:  lane_ctrl.cap_b  = 1'b1;
      S_PMUL: lane_ctrl.do_mul = 1'b1;
      default: ;
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      dim <= CFG_W'(1);
    end else if (cfg_we) begin
      dim <= cfg_wdata;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      total    <= '0;
      m_tvalid <= 1'b0;
      fct      <= '0;
    end else begin
      // result valid: set when the output register loads, cleared when taken
      if ((state == S_OUT) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_pos <= 1'b0;
            frac    <= (frac_in > ONE_Q16) ? ONE_Q16 : frac_in;
            case (s_tuser)
              CMD_CLEAR: begin
                res_status <= STAT_OK;
                state      <= S_OUT;
                count      <= '0;
                total      <= '0;
              end
              CMD_APPEND: begin
                state <= S_OUT;
                if (app_we) begin
                  res_status <= STAT_OK;
                  count      <= count + 1'b1;
                end else begin
                  res_status <= STAT_FULL;
                end
              end
              CMD_QUERY: begin
                if (count == '0) begin
                  res_status <= STAT_EMPTY;
                  state      <= S_OUT;
                end else begin
                  res_status <= STAT_OK;
                  total      <= '0;
                  seg        <= CW'(1);
                  state      <= (count == CW'(1)) ? S_WANT : S_RDA;
                end
              end
              default: begin
                res_status <= STAT_OK;
                state      <= S_OUT;
              end
            endcase
          end
        end
        S_RDA: state <= S_RDB;
        S_RDB: state <= S_CPB;
        S_CPB: state <= S_SQ;
        S_SQ: begin
          k     <= '0;
          acc   <= '0;
          state <= S_ACC;
        end
        // merge the lane squares one lane a cycle
        S_ACC: begin
          acc <= acc_sum;
          k   <= k + 1'b1;
          if (k == d_eff - 1'b1) begin
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            total <= total + LEN_W'(sq_root);
            if (seg == count - 1'b1) begin
              state <= S_WANT;
            end else begin
              seg   <= seg + 1'b1;
              state <= S_RDA;
            end
          end
        end
        S_WANT: begin
          wanted <= tf[LEN_W+15:16];
          act    <= '0;
          last   <= '0;
          fct    <= '0;
          if (frac == '0) begin
            idx   <= '0;
            p0    <= '0;
            p1    <= '0;
            state <= S_PRA;
          end else if (frac == ONE_Q16) begin
            idx   <= count - 1'b1;
            p0    <= AW'(count - 1'b1);
            p1    <= AW'(count - 1'b1);
            state <= S_PRA;
          end else begin
            idx   <= '0;
            state <= S_WALK;
          end
        end
        // walk segments until the wanted length is reached or the segments run out
        S_WALK: begin
          if (walk_go) begin
            state <= S_WADD;
          end else if (idx == '0) begin
            p0    <= '0;
            p1    <= '0;
            state <= S_PRA;
          end else begin
            idx   <= idx - 1'b1;
            p0    <= AW'(idx - 1'b1);
            p1    <= idx[AW-1:0];
            state <= (last == '0) ? S_PRA : S_DIV;
          end
        end
        S_WADD: begin
          last  <= sl_rdata;
          act   <= act + LEN_W'(sl_rdata);
          idx   <= idx + 1'b1;
          state <= S_WALK;
        end
        S_DIV: begin
          if (dv_done) begin
            fct   <= (dv_quo > ONE_Q16) ? ONE_Q16 : dv_quo;
            state <= S_PRA;
          end
        end
        S_PRA: state <= S_PRB;
        S_PRB: state <= S_PCB;
        S_PCB: state <= S_PMUL;
        S_PMUL: begin
          res_pos <= 1'b1;
          state   <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if ((state == S_OUT) && out_free) begin
      m_tuser <= res_status;
      for (int i = 0; i < FIELD_LANES; i++) begin
        m_tdata[i*COORD_W +: COORD_W] <= pos_sel[i];
      end
      m_tdata[SEG_LSB +: SEG_W] <= res_pos ? SEG_W'(idx) : '0;
    end
  end

  // checks
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_POINTS)) else $error("point count above store size");
  a_sqrt_owner: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> (state == S_SQRT)) else $error("square root finished out of turn");
  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    dv_done |-> (state == S_DIV)) else $error("divider finished out of turn");
  a_factor_max: assert property (@(posedge clk) disable iff (rst)
    fct <= ONE_Q16) else $error("factor above one");
  a_walk_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (idx < count)) else $error("walk index past last point");

endmodule
